### hdl/assert_macros.svh
// Assertion helper macros shared by the RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define BFCA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, but also skips the first edge after reset is released.
`define BFCA_ASSERT_SETTLED(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        $past(i_rst_n) |-> prop) else $error(msg);

`endif

### hdl/bfca_pkg.sv
// Shared constants and types of the best-fit allocator core.
// No dependencies.
`timescale 1ns / 1ps

package bfca_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_BITS    = 48;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam t_addr HDR     = t_addr'(HEADER_BYTES);
    localparam t_cnt  CNT_MAX = t_cnt'(MAX_SEGMENTS);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {KIND_PLAIN, KIND_LEFT, KIND_RIGHT} t_kind;
    typedef enum logic [2:0] {OP_NOP, OP_WRITE, OP_INSERT, OP_WRDEL, OP_DEL} t_op;

    typedef struct packed {
        t_addr start;
        t_addr pay;
    } t_seg;

    // Record that walks the cell row during a scan.
    typedef struct packed {
        logic  hit;
        t_kind kind;
        t_idx  idx;
        t_seg  cap;
        logic  nxt_v;
        t_seg  nxt;
    } t_scan;

    // Request values seen by every cell.
    typedef struct packed {
        logic  alloc;
        t_addr key;
        t_addr amt;
        t_addr key_end;
        t_cnt  count;
    } t_bcast;

    typedef struct packed {
        t_op  op;
        t_idx idx;
        t_seg seg;
    } t_cmd;

endpackage

### hdl/bfca_cell.sv
// One table slot: holds a segment, steps the scan record, shifts on commands.
// Depends on bfca_pkg.
`timescale 1ns / 1ps

module bfca_cell (
    input  logic            i_clk,
    input  bfca_pkg::t_idx   i_index,
    input  bfca_pkg::t_bcast i_bc,
    input  bfca_pkg::t_cmd   i_cmd,
    input  bfca_pkg::t_seg   i_left,
    input  bfca_pkg::t_seg   i_right,
    output bfca_pkg::t_seg   o_seg,
    input  bfca_pkg::t_scan  i_rec,
    output bfca_pkg::t_scan  o_rec
);
    import bfca_pkg::*;

    t_seg  r_seg;
    t_scan r_rec, n_rec;
    logic  w_valid;
    t_addr w_end;

    assign w_valid = t_cnt'(i_index) < i_bc.count;
    assign w_end   = r_seg.start + HDR + r_seg.pay;

    always_comb begin
        n_rec = i_rec;
        if (i_bc.alloc) begin
            if (w_valid && r_seg.pay >= i_bc.amt &&
                (!i_rec.hit || r_seg.pay < i_rec.cap.pay)) begin
                n_rec.hit = 1'b1;
                n_rec.idx = i_index;
                n_rec.cap = r_seg;
            end
        end else if (!i_rec.hit) begin
            if (w_valid && r_seg.start <= i_bc.key) begin
                if (w_end == i_bc.key) begin
                    n_rec.hit  = 1'b1;
                    n_rec.kind = KIND_LEFT;
                    n_rec.idx  = i_index;
                    n_rec.cap  = r_seg;
                end
            end else begin
                // first slot past the key, or first unused slot: insert point
                n_rec.hit  = 1'b1;
                n_rec.idx  = i_index;
                n_rec.cap  = r_seg;
                n_rec.kind = (w_valid && i_bc.key_end == r_seg.start) ? KIND_RIGHT
                                                                      : KIND_PLAIN;
            end
        end else if (w_valid && i_rec.idx == i_index - 1'b1) begin
            // neighbor after the decided slot, for a follow-on merge
            n_rec.nxt_v = 1'b1;
            n_rec.nxt   = r_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        case (i_cmd.op)
            OP_WRITE: begin
                if (i_cmd.idx == i_index) r_seg <= i_cmd.seg;
            end
            OP_INSERT: begin
                if (i_cmd.idx == i_index) r_seg <= i_cmd.seg;
                else if (i_index > i_cmd.idx) r_seg <= i_left;
            end
            OP_WRDEL: begin
                if (i_cmd.idx == i_index) r_seg <= i_cmd.seg;
                else if (i_index > i_cmd.idx) r_seg <= i_right;
            end
            OP_DEL: begin
                if (i_index >= i_cmd.idx) r_seg <= i_right;
            end
            default: begin
            end
        endcase
    end

    assign o_seg = r_seg;
    assign o_rec = r_rec;

endmodule

### hdl/best_fit_coalescing_allocator_core.sv
// Best-fit free-segment allocator: a row of MAX_SEGMENTS cells holds the free
// table in address order. Each request is accepted in IDLE, then a scan
// record steps through one cell per cycle in SCAN, CALC works out the update
// and APPLY applies it to all cells at once (after any wait for the result
// register to drain). One request is in flight at a time; the
// result register lets a new request enter while the last result is unread.
// Depends on bfca_pkg, bfca_cell and assert_macros.svh.
`timescale 1ns / 1ps

module best_fit_coalescing_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [47:0] i_req_size,
    input  logic [47:0] i_req_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [47:0] o_grant_addr,
    output logic [47:0] o_grant_size
);
    import bfca_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_APPLY} t_state;

    t_state     r_state;
    t_cnt       r_count, r_tick;
    logic [1:0] r_mode;
    t_addr      r_key, r_amt, r_key_end;
    t_op        r_op, n_op;
    t_idx       r_idx;
    t_addr      r_nstart, r_npay, n_nstart, n_npay;
    logic       r_absorb, n_absorb;
    logic       r_nxt_v;
    t_seg       r_nxt;
    logic [1:0] r_status, n_status;
    t_addr      r_gaddr, r_gsize, n_gaddr, n_gsize;
    logic       r_o_valid;
    logic [1:0] r_o_status;
    t_addr      r_o_gaddr, r_o_gsize;

    t_bcast w_bc;
    t_cmd   w_cmd;
    t_scan  w_rec [MAX_SEGMENTS+1];
    t_seg   w_seg [MAX_SEGMENTS];
    t_scan  w_last;
    logic   w_split, w_fire, w_merge;
    t_addr  w_new_end;

    assign w_bc.alloc   = (r_mode == MODE_ALLOC);
    assign w_bc.key     = r_key;
    assign w_bc.amt     = r_amt;
    assign w_bc.key_end = r_key_end;
    assign w_bc.count   = r_count;

    assign w_rec[0] = '0;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        t_seg w_left, w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_seg[g-1];
        end
        if (g == MAX_SEGMENTS - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_seg[g+1];
        end
        bfca_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_idx'(g)),
            .i_bc    (w_bc),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_seg   (w_seg[g]),
            .i_rec   (w_rec[g]),
            .o_rec   (w_rec[g+1])
        );
    end

    assign w_last = w_rec[MAX_SEGMENTS];

    // split needs room for a header plus one byte; compared one bit wider
    assign w_split = {1'b0, w_last.cap.pay} >=
                     ({1'b0, r_amt} + {1'b0, HDR} + {{ADDR_BITS{1'b0}}, 1'b1});

    assign w_new_end = r_nstart + HDR + r_npay;
    assign w_merge   = r_absorb && r_nxt_v && (r_nxt.start == w_new_end);
    assign w_fire    = (r_state == ST_APPLY) && (!r_o_valid || i_out_ready);

    always_comb begin
        w_cmd.op        = OP_NOP;
        w_cmd.idx       = r_idx;
        w_cmd.seg.start = r_nstart;
        w_cmd.seg.pay   = r_npay;
        if (w_fire) begin
            if (w_merge) begin
                w_cmd.op      = OP_WRDEL;
                w_cmd.seg.pay = r_npay + HDR + r_nxt.pay;
            end else begin
                w_cmd.op = r_op;
            end
        end
    end

    // update decided from the finished scan record
    always_comb begin
        n_op     = OP_NOP;
        n_absorb = 1'b0;
        n_status = STAT_OK;
        n_gaddr  = '0;
        n_gsize  = '0;
        n_nstart = r_key;
        n_npay   = r_amt;
        case (r_mode)
            MODE_ALLOC: begin
                if (!w_last.hit) begin
                    n_status = STAT_NOFIT;
                end else begin
                    n_gaddr = w_last.cap.start + HDR;
                    if (w_split) begin
                        n_op     = OP_WRITE;
                        n_nstart = w_last.cap.start + HDR + r_amt;
                        n_npay   = w_last.cap.pay - r_amt - HDR;
                        n_gsize  = r_amt;
                    end else begin
                        n_op    = OP_DEL;
                        n_gsize = w_last.cap.pay;
                    end
                end
            end
            MODE_FREE, MODE_ADD: begin
                if (!w_last.hit) begin
                    n_status = STAT_FULL;
                end else begin
                    case (w_last.kind)
                        KIND_LEFT: begin
                            n_op     = OP_WRITE;
                            n_absorb = 1'b1;
                            n_nstart = w_last.cap.start;
                            n_npay   = w_last.cap.pay + HDR + r_amt;
                        end
                        KIND_RIGHT: begin
                            n_op     = OP_WRITE;
                            n_absorb = 1'b1;
                            n_npay   = r_amt + HDR + w_last.cap.pay;
                        end
                        default: begin
                            if (r_count >= CNT_MAX) n_status = STAT_FULL;
                            else n_op = OP_INSERT;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_fire) r_o_valid <= 1'b1;
            else if (i_out_ready) r_o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mode    <= i_mode;
                        r_key     <= (i_mode == MODE_FREE) ? i_req_addr - HDR : i_req_addr;
                        r_amt     <= (i_mode == MODE_ADD) ? i_req_size - HDR : i_req_size;
                        r_key_end <= i_req_addr + i_req_size;
                        r_tick    <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_tick <= r_tick + 1'b1;
                    if (r_tick == t_cnt'(MAX_SEGMENTS - 1)) r_state <= ST_CALC;
                end
                ST_CALC: begin
                    r_op     <= n_op;
                    r_absorb <= n_absorb;
                    r_status <= n_status;
                    r_gaddr  <= n_gaddr;
                    r_gsize  <= n_gsize;
                    r_idx    <= w_last.idx;
                    r_nxt_v  <= w_last.nxt_v;
                    r_nxt    <= w_last.nxt;
                    r_nstart <= n_nstart;
                    r_npay   <= n_npay;
                    r_state  <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (w_fire) begin
                        case (w_cmd.op)
                            OP_INSERT:       r_count <= r_count + 1'b1;
                            OP_DEL, OP_WRDEL: r_count <= r_count - 1'b1;
                            default:         r_count <= r_count;
                        endcase
                        r_o_status <= r_status;
                        r_o_gaddr  <= r_gaddr;
                        r_o_gsize  <= r_gsize;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_grant_addr = r_o_gaddr;
    assign o_grant_size = r_o_gsize;

    `BFCA_ASSERT(a_count_max, r_count <= CNT_MAX, "segment count above table size")
    `BFCA_ASSERT(a_accept_scan, (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN), "accepted beat did not start a scan")
    `BFCA_ASSERT_SETTLED(a_count_only_apply, (r_count != $past(r_count)) |-> ($past(r_state) == ST_APPLY), "count moved outside apply")
    `BFCA_ASSERT_SETTLED(a_count_step, (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1), "count moved by more than one")
    `BFCA_ASSERT(a_full_no_insert, (w_cmd.op == OP_INSERT) |-> (r_count < CNT_MAX), "insert into a full table")

endmodule

### tb/sv/tb_best_fit_coalescing_allocator_core.sv
// Testbench for best_fit_coalescing_allocator_core: a free-table predictor
// scores every result beat against requests as they enter the core.
// Depends on bfca_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_best_fit_coalescing_allocator_core;
    import bfca_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] status;
        t_addr      gaddr;
        t_addr      gsize;
    } t_grant;

    typedef struct {
        t_addr uaddr;
        t_addr size;
    } t_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [47:0] i_req_size;
    logic [47:0] i_req_addr;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [47:0] o_grant_addr;
    logic [47:0] o_grant_size;

    best_fit_coalescing_allocator_core uut (.*);

    // free-table shadow
    t_addr  fl_start[MAX_SEGMENTS];
    t_addr  fl_pay[MAX_SEGMENTS];
    int     fl_cnt;

    t_grant grants_due[$];
    t_block live_blocks[$];
    int     n_err, n_checked, n_nofit, n_full, n_merge_items;
    int     hold_left = 0, stall_left = 0;
    int     hold_asked = 0, hold_seen = 0;
    bit     quiet;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_addr rand48();
        return t_addr'({$urandom, $urandom});
    endfunction

    function automatic t_addr seg_end(int i);
        return fl_start[i] + HDR + fl_pay[i];
    endfunction

    function automatic void remove_at(int i);
        for (int k = i; k < fl_cnt - 1; k++) begin
            fl_start[k] = fl_start[k+1];
            fl_pay[k]   = fl_pay[k+1];
        end
        fl_cnt--;
    endfunction

    function automatic void absorb_next(int i);
        if (i + 1 < fl_cnt && fl_start[i+1] == seg_end(i)) begin
            fl_pay[i] = fl_pay[i] + HDR + fl_pay[i+1];
            remove_at(i + 1);
        end
    endfunction

    function automatic logic [1:0] insert_seg(t_addr start, t_addr pay);
        int p;
        p = 0;
        while (p < fl_cnt && fl_start[p] <= start) begin
            if (seg_end(p) == start) begin
                fl_pay[p] = fl_pay[p] + HDR + pay;
                absorb_next(p);
                n_merge_items++;
                return STAT_OK;
            end
            p++;
        end
        if (p < fl_cnt && t_addr'(start + HDR + pay) == fl_start[p]) begin
            fl_pay[p]   = pay + HDR + fl_pay[p];
            fl_start[p] = start;
            absorb_next(p);
            n_merge_items++;
            return STAT_OK;
        end
        if (fl_cnt >= MAX_SEGMENTS) return STAT_FULL;
        for (int k = fl_cnt; k > p; k--) begin
            fl_start[k] = fl_start[k-1];
            fl_pay[k]   = fl_pay[k-1];
        end
        fl_start[p] = start;
        fl_pay[p]   = pay;
        fl_cnt++;
        return STAT_OK;
    endfunction

    function automatic t_grant predict_grant(logic [1:0] mode, t_addr size, t_addr addr);
        t_grant g;
        int best;
        g = '{STAT_OK, '0, '0};
        best = -1;
        case (mode)
            MODE_ALLOC: begin
                for (int i = 0; i < fl_cnt; i++)
                    if (fl_pay[i] >= size && (best < 0 || fl_pay[i] < fl_pay[best]))
                        best = i;
                if (best < 0) begin
                    g.status = STAT_NOFIT;
                end else begin
                    g.gaddr = fl_start[best] + HDR;
                    // split test is done without wrap
                    if ({16'd0, fl_pay[best]} >= {16'd0, size} + 64'(HEADER_BYTES) + 64'd1) begin
                        fl_pay[best]   = fl_pay[best] - size - HDR;
                        fl_start[best] = fl_start[best] + HDR + size;
                        g.gsize = size;
                    end else begin
                        g.gsize = fl_pay[best];
                        remove_at(best);
                    end
                end
            end
            MODE_FREE: g.status = insert_seg(addr - HDR, size);
            MODE_ADD:  g.status = insert_seg(addr, size - HDR);
            default: ;
        endcase
        return g;
    endfunction

    task automatic send_req(logic [1:0] mode, t_addr size, t_addr addr);
        t_grant g;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode     = mode;
        i_req_size = size;
        i_req_addr = addr;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        g = predict_grant(mode, size, addr);
        grants_due.push_back(g);
        if (g.status == STAT_NOFIT) n_nofit++;
        if (g.status == STAT_FULL) n_full++;
        if (mode == MODE_ALLOC && g.status == STAT_OK)
            live_blocks.push_back('{g.gaddr, g.gsize});
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // result side: random back-pressure plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen   <= hold_asked;
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (grants_due.size() == 0) begin
                n_err++;
                $display("%0t: result beat with nothing expected (status %0d)",
                         $time, o_status);
            end else begin
                g = grants_due.pop_front();
                if (o_status !== g.status || o_grant_addr !== g.gaddr ||
                    o_grant_size !== g.gsize) begin
                    n_err++;
                    $display("%0t: mismatch exp st=%0d addr=%h size=%h got st=%0d addr=%h size=%h",
                             $time, g.status, g.gaddr, g.gsize,
                             o_status, o_grant_addr, o_grant_size);
                end
            end
        end
    end

    task automatic free_random_live();
        int k;
        t_block b;
        if (live_blocks.size() == 0) return;
        k = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[k];
        live_blocks.delete(k);
        send_req(MODE_FREE, b.size, b.uaddr);
    endtask

    task automatic test_directed();
        send_req(MODE_ALLOC, 48'd0, 48'd0);                      // empty table
        send_req(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_req(MODE_ADD, 48'h1000, 48'h10_0000);
        send_req(MODE_ADD, 48'h1000, 48'h10_1000);               // merge on left
        send_req(MODE_ADD, 48'h1000, 48'h0F_F000);               // merge on right
        send_req(MODE_ADD, 48'h800, 48'h10_3000);
        send_req(MODE_ADD, 48'h1000, 48'h10_2000);               // bridges both
        send_req(MODE_ALLOC, 48'h40, 48'd0);                      // split
        send_req(MODE_ALLOC, 48'h7F0, 48'd0);
        send_req(MODE_ADD, 48'h20, 48'h20_0000);
        send_req(MODE_ALLOC, 48'h8, 48'd0);                       // remainder too small
        send_req(MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 48'd0);          // no fit
        send_req(MODE_ADD, 48'd5, 48'h30_0000);                   // payload wraps
        send_req(MODE_ALLOC, 48'hFFFF_FFFF_FFF0, 48'd0);
        send_req(MODE_ADD, 48'h40, 48'hFFFF_FFFF_FFF0);           // end wraps
        send_req(MODE_FREE, 48'h30, 48'd0);                       // start wraps
        send_req(MODE_ADD, 48'h100, 48'h50_0000);
        send_req(MODE_ADD, 48'h80, 48'h50_0000);                  // duplicate start
        send_req(MODE_ALLOC, 48'd0, 48'd0);
        send_req(MODE_FREE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_req(MODE_UNUSED, 48'd0, 48'd0);
    endtask

    task automatic test_table_full();
        for (int k = 0; k < 70; k++)
            send_req(MODE_ADD, 48'h100, 48'h8000_0000_0000 + t_addr'(k) * 48'h1000);
        for (int k = 0; k < 70; k++)
            send_req(MODE_ALLOC, 48'hF0, 48'd0);
    endtask

    task automatic test_backpressure();
        hold_asked++;
        for (int k = 0; k < 6; k++)
            send_req(MODE_ALLOC, t_addr'($urandom_range(1, 64)), 48'd0);
    endtask

    task automatic test_random(int n_items);
        int r;
        t_addr base;
        for (int k = 0; k < n_items; k++) begin
            if (k % 200 == 0) quiet = !quiet;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_req(MODE_ALLOC, t_addr'($urandom_range(0, 300)), rand48());
            end else if (r < 65 && live_blocks.size() > 0) begin
                free_random_live();
            end else if (r < 78) begin
                base = t_addr'($urandom_range(0, 255)) << 20;
                send_req(MODE_ADD, t_addr'($urandom_range(64, 4096)), base);
            end else if (r < 85) begin
                send_req(MODE_ALLOC, rand48() >> $urandom_range(0, 47), rand48());
            end else if (r < 90) begin
                send_req(MODE_UNUSED, rand48(), rand48());
            end else begin
                send_req($urandom_range(0, 1) ? MODE_FREE : MODE_ADD,
                         rand48() >> $urandom_range(0, 47), rand48());
            end
        end
        // hand back what is still out so the frees get full coverage
        while (live_blocks.size() > 0) free_random_live();
    endtask

    initial begin
        int waited;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_ALLOC;
        i_req_size  = '0;
        i_req_addr  = '0;
        quiet       = 1'b0;
        fl_cnt      = 0;
        n_err = 0; n_checked = 0; n_nofit = 0; n_full = 0; n_merge_items = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_backpressure();
        test_random(1000);

        waited = 0;
        while (grants_due.size() > 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (100) @(negedge i_clk);

        $display("Covered %0d result beats: %0d no-fit, %0d table-full, %0d merging inserts.",
                 n_checked, n_nofit, n_full, n_merge_items);
        if (n_err == 0 && grants_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (grants_due.size() > 0)
                $display("%0t: %0d results never arrived", $time, grants_due.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
